/* rtl/mi3_pkg.sv */
// Shared constants and item types of the 3x3 matrix inverse core.
package mi3_pkg;

  localparam int unsigned EntryWidth = 32;
  localparam int unsigned FracBits   = 16;

  typedef logic signed [EntryWidth-1:0] entry_t;

  typedef struct packed {
    entry_t in_r0c0;
    entry_t in_r0c1;
    entry_t in_r0c2;
    entry_t in_r1c0;
    entry_t in_r1c1;
    entry_t in_r1c2;
    entry_t in_r2c0;
    entry_t in_r2c1;
    entry_t in_r2c2;
  } in_item_t;

  typedef struct packed {
    entry_t out_r0c0;
    entry_t out_r0c1;
    entry_t out_r0c2;
    entry_t out_r1c0;
    entry_t out_r1c1;
    entry_t out_r1c2;
    entry_t out_r2c0;
    entry_t out_r2c1;
    entry_t out_r2c2;
    logic   singular;
    logic   overflow;
  } out_item_t;

endpackage

/* rtl/matrix3_inverse_core.sv */
// 3x3 matrix inverse by adjugate and rounded long division, fully pipelined.
// Throughput: one item per cycle while the output is not stalled; the division takes
//   one quotient bit per stage over EntryWidth + 1 stages, nine lanes side by side.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Reset (rst_ni low, asynchronous) clears all valid bits; data registers keep state.
module matrix3_inverse_core #(
  parameter int unsigned FRAC_BITS = mi3_pkg::FracBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mi3_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mi3_pkg::out_item_t  out_item_o
);

  localparam int unsigned EW   = mi3_pkg::EntryWidth;
  localparam int unsigned PW   = 2 * EW;          // entry product
  localparam int unsigned CW   = PW + 1;          // cofactor
  localparam int unsigned PPW  = 2 * EW + 1;      // partial product of det term
  localparam int unsigned DTW  = 3 * EW + 3;      // determinant
  localparam int unsigned UWA  = CW + 2 * FRAC_BITS + 2;
  localparam int unsigned UWB  = DTW + EW + 2;
  localparam int unsigned UW   = (UWA > UWB) ? UWA : UWB;  // divider width
  localparam int unsigned NDIV = EW + 1;          // quotient bits

  // operand indexes of the 2x2 minors: adj = e[A]*e[B] - e[C]*e[D]
  localparam int unsigned MA [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int unsigned MB [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int unsigned MC [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int unsigned MD [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  logic en;
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  logic signed [EW-1:0] e_in [9];
  assign e_in[0] = in_item_i.in_r0c0;
  assign e_in[1] = in_item_i.in_r0c1;
  assign e_in[2] = in_item_i.in_r0c2;
  assign e_in[3] = in_item_i.in_r1c0;
  assign e_in[4] = in_item_i.in_r1c1;
  assign e_in[5] = in_item_i.in_r1c2;
  assign e_in[6] = in_item_i.in_r2c0;
  assign e_in[7] = in_item_i.in_r2c1;
  assign e_in[8] = in_item_i.in_r2c2;

  // valid bits of the front stages
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic dv_q [NDIV+1];
  logic out_v_q;

  // payload registers
  logic signed [EW-1:0]  ent1_q [9], ent2_q [9], ent3_q [9], ent4_q [9], ent5_q [9];
  logic signed [PW-1:0]  prod_d [18], prod_q [18];
  logic signed [CW-1:0]  adj_d [9], adj2_q [9], adj3_q [9], adj4_q [9];
  logic signed [PPW-1:0] plo_d [3], plo_q [3], phi_d [3], phi_q [3];
  logic signed [DTW-1:0] det_d, det_q;
  logic [UW-1:0]         x_d [9], x5_q [9], y_d, y5_q;
  logic                  neg_d [9], neg5_q [9], sing_d, sing5_q;

  // divider pipeline, index 0 holds the range check stage
  logic [UW-1:0]         dr_q [NDIV+1][9];
  logic [EW:0]           dq_q [NDIV+1][9];
  logic                  dbig_q [NDIV+1][9];
  logic                  dneg_q [NDIV+1][9];
  logic [UW-1:0]         dy_q [NDIV+1];
  logic                  dsing_q [NDIV+1];
  logic signed [EW-1:0]  dent_q [NDIV+1][9];

  mi3_pkg::out_item_t out_d, out_q;

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      v5_q    <= 1'b0;
      out_v_q <= 1'b0;
      for (int s = 0; s <= NDIV; s++) dv_q[s] <= 1'b0;
    end else if (en) begin
      v1_q     <= in_valid_i;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      v4_q     <= v3_q;
      v5_q     <= v4_q;
      dv_q[0]  <= v5_q;
      for (int s = 1; s <= NDIV; s++) dv_q[s] <= dv_q[s-1];
      out_v_q  <= dv_q[NDIV];
    end
  end

  // stage 1: products of entry pairs
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      prod_d[2*k]   = PW'(e_in[MA[k]]) * PW'(e_in[MB[k]]);
      prod_d[2*k+1] = PW'(e_in[MC[k]]) * PW'(e_in[MD[k]]);
    end
  end

  // stage 2: cofactors
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      adj_d[k] = CW'(prod_q[2*k]) - CW'(prod_q[2*k+1]);
    end
  end

  function automatic logic [EW-1:0] adj_d_lo(input logic signed [CW-1:0] a);
    return a[EW-1:0];
  endfunction

  // stage 3: first-row terms split into low and high partial products
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      plo_d[k] = PPW'(ent2_q[k]) * PPW'($signed({1'b0, adj_d_lo(adj2_q[3*k])}));
      phi_d[k] = PPW'(ent2_q[k]) * PPW'($signed(adj2_q[3*k][CW-1:EW]));
    end
  end

  // stage 4: determinant
  always_comb begin
    det_d = '0;
    for (int k = 0; k < 3; k++) begin
      det_d = det_d + (DTW'(phi_q[k]) <<< EW) + DTW'(plo_q[k]);
    end
  end

  // stage 5: magnitudes, signs and rounded-division operands
  logic [DTW-1:0] dmag;
  logic [CW-1:0]  amag [9];
  always_comb begin
    dmag   = det_q[DTW-1] ? DTW'(-det_q) : DTW'(det_q);
    sing_d = (det_q == '0);
    y_d    = UW'(dmag) << 1;
    for (int k = 0; k < 9; k++) begin
      amag[k]  = adj4_q[k][CW-1] ? CW'(-adj4_q[k]) : CW'(adj4_q[k]);
      neg_d[k] = adj4_q[k][CW-1] ^ det_q[DTW-1];
      x_d[k]   = (UW'(amag[k]) << (2 * FRAC_BITS + 1)) + UW'(dmag);
    end
  end

  // front payload registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      ent1_q <= e_in;
      prod_q <= prod_d;
      ent2_q <= ent1_q;
      adj2_q <= adj_d;
      ent3_q <= ent2_q;
      adj3_q <= adj2_q;
      plo_q  <= plo_d;
      phi_q  <= phi_d;
      ent4_q <= ent3_q;
      adj4_q <= adj3_q;
      det_q  <= det_d;
      ent5_q <= ent4_q;
      x5_q   <= x_d;
      y5_q   <= y_d;
      neg5_q <= neg_d;
      sing5_q <= sing_d;
    end
  end

  // range check: quotient would need more than EW+1 bits
  always_ff @(posedge clk_i) begin
    if (en) begin
      dy_q[0]    <= y5_q;
      dsing_q[0] <= sing5_q;
      dent_q[0]  <= ent5_q;
      for (int k = 0; k < 9; k++) begin
        dr_q[0][k]   <= x5_q[k];
        dq_q[0][k]   <= '0;
        dneg_q[0][k] <= neg5_q[k];
        dbig_q[0][k] <= (x5_q[k] >= (y5_q << (EW + 1)));
      end
    end
  end

  // restoring division, one quotient bit per stage, MSB first
  for (genvar j = 0; j < NDIV; j++) begin : g_div
    localparam int unsigned SH = EW - j;
    logic [UW-1:0] ysh;
    assign ysh = dy_q[j] << SH;
    always_ff @(posedge clk_i) begin
      if (en) begin
        dy_q[j+1]    <= dy_q[j];
        dsing_q[j+1] <= dsing_q[j];
        dent_q[j+1]  <= dent_q[j];
        for (int k = 0; k < 9; k++) begin
          dneg_q[j+1][k] <= dneg_q[j][k];
          dbig_q[j+1][k] <= dbig_q[j][k];
          if (dr_q[j][k] >= ysh) begin
            dr_q[j+1][k] <= dr_q[j][k] - ysh;
            dq_q[j+1][k] <= dq_q[j][k] | ((EW+1)'(1) << SH);
          end else begin
            dr_q[j+1][k] <= dr_q[j][k];
            dq_q[j+1][k] <= dq_q[j][k];
          end
        end
      end
    end
  end

  // saturation, sign and singular pass-through
  logic [EW:0]          lim [9], mag [9], sres [9];
  logic                 sat [9];
  logic signed [EW-1:0] res [9];
  logic                 any_sat;
  always_comb begin
    any_sat = 1'b0;
    for (int k = 0; k < 9; k++) begin
      lim[k]  = {2'b00, {(EW-1){1'b1}}} + (EW+1)'(dneg_q[NDIV][k]);
      sat[k]  = dbig_q[NDIV][k] || (dq_q[NDIV][k] > lim[k]);
      mag[k]  = sat[k] ? lim[k] : dq_q[NDIV][k];
      sres[k] = dneg_q[NDIV][k] ? -mag[k] : mag[k];
      res[k]  = dsing_q[NDIV] ? dent_q[NDIV][k] : $signed(sres[k][EW-1:0]);
      any_sat = any_sat | sat[k];
    end
    out_d.out_r0c0 = res[0];
    out_d.out_r0c1 = res[1];
    out_d.out_r0c2 = res[2];
    out_d.out_r1c0 = res[3];
    out_d.out_r1c1 = res[4];
    out_d.out_r1c2 = res[5];
    out_d.out_r2c0 = res[6];
    out_d.out_r2c1 = res[7];
    out_d.out_r2c2 = res[8];
    out_d.singular = dsing_q[NDIV];
    out_d.overflow = !dsing_q[NDIV] && any_sat;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

  // a singular matrix never reports saturation
  a_sing_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.singular && out_item_o.overflow))
    else $error("singular result flagged overflow");

  // an accepted item enters the first stage
  a_accept_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v1_q)
    else $error("accepted item lost at stage 1");

  // the last divider stage reaches the output when the pipe moves
  a_div_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_q[NDIV] && en) |=> out_valid_o)
    else $error("item lost between divider and output");

endmodule

/* dv/matrix3_inverse_core_tb.sv */
// Self-checking testbench for the pipelined 3x3 matrix inverse core.
`timescale 1ns / 1ps

module matrix3_inverse_core_tb;

  localparam int NumRandom = 430;
  localparam int WatchLimit = 5000;
  localparam int HoldCycles = 300;
  localparam int DrainCycles = 80;
  localparam logic signed [31:0] One = 32'sh0001_0000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  mi3_pkg::in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  mi3_pkg::out_item_t out_item_o;

  mi3_pkg::in_item_t pending_mats[$];
  mi3_pkg::out_item_t expected_inverses[$];
  int total_items = 0;
  int sent_items = 0;
  int got_items = 0;
  int errors = 0;
  int idle_cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  matrix3_inverse_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Inverse of one matrix: exact adjugate, rounded quotient, saturation.
  function automatic mi3_pkg::out_item_t invert_matrix(mi3_pkg::in_item_t m);
    logic signed [255:0] e[9];
    logic signed [255:0] adj[9];
    logic signed [255:0] det, amag;
    logic [255:0] dmag, q, lim;
    logic [289:0] flat;
    logic [287:0] src;
    logic [31:0] v;
    logic ovf, neg;
    src = m;
    for (int k = 0; k < 9; k++) e[k] = $signed(src[287 - 32 * k -: 32]);
    adj[0] = e[4] * e[8] - e[5] * e[7];
    adj[1] = e[2] * e[7] - e[1] * e[8];
    adj[2] = e[1] * e[5] - e[2] * e[4];
    adj[3] = e[5] * e[6] - e[3] * e[8];
    adj[4] = e[0] * e[8] - e[2] * e[6];
    adj[5] = e[2] * e[3] - e[0] * e[5];
    adj[6] = e[3] * e[7] - e[4] * e[6];
    adj[7] = e[1] * e[6] - e[0] * e[7];
    adj[8] = e[0] * e[4] - e[1] * e[3];
    det = e[0] * adj[0] + e[1] * adj[3] + e[2] * adj[6];
    if (det == 0) begin
      flat = {src, 1'b1, 1'b0};
      return mi3_pkg::out_item_t'(flat);
    end
    dmag = det < 0 ? -det : det;
    ovf = 1'b0;
    for (int k = 0; k < 9; k++) begin
      neg = (adj[k] < 0) != (det < 0);
      amag = adj[k] < 0 ? -adj[k] : adj[k];
      q = ((amag << (2 * mi3_pkg::FracBits + 1)) + dmag) / (dmag << 1);
      lim = neg ? 256'h8000_0000 : 256'h7fff_ffff;
      if (q > lim) begin
        q = lim;
        ovf = 1'b1;
      end
      v = neg ? -q[31:0] : q[31:0];
      flat[289 - 32 * k -: 32] = v;
    end
    flat[1] = 1'b0;
    flat[0] = ovf;
    return mi3_pkg::out_item_t'(flat);
  endfunction

  function automatic mi3_pkg::in_item_t make_matrix(logic signed [31:0] a, b, c, d, e, f,
                                                    g, h, i);
    return mi3_pkg::in_item_t'({a, b, c, d, e, f, g, h, i});
  endfunction

  function automatic logic signed [31:0] pick_entry(int kind);
    case (kind)
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      default: return $signed($urandom_range(0, 32'h0000_0400)) - 32'sh0000_0200;
    endcase
  endfunction

  // Random matrix: raw noise, moderate values, tiny values, or a singular one
  function automatic mi3_pkg::in_item_t random_matrix();
    logic signed [31:0] r[9];
    int kind, style;
    style = $urandom_range(0, 9);
    kind = style < 2 ? 0 : (style < 7 ? 1 : 2);
    for (int k = 0; k < 9; k++) r[k] = pick_entry(kind);
    if (style >= 5 && style < 7) begin
      for (int k = 0; k < 3; k++) r[k] = r[k] + (One <<< 2);
      r[0] = r[0] + (One <<< 3); r[4] = r[4] + (One <<< 3); r[8] = r[8] + (One <<< 3);
    end
    if (style == 9) begin
      // repeated row, so the determinant is zero
      for (int k = 0; k < 3; k++) r[3 + k] = r[k];
    end
    return make_matrix(r[0], r[1], r[2], r[3], r[4], r[5], r[6], r[7], r[8]);
  endfunction

  function automatic int phase_of(int n);
    return n < total_items / 3 ? 0 : (n < 2 * total_items / 3 ? 1 : 2);
  endfunction

  // Driver: one matrix per item, idling at the rate of the current phase
  always @(posedge clk_i) begin
    int pct;
    pct = phase_of(sent_items) == 0 ? 38 : (phase_of(sent_items) == 1 ? 79 : 0);
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_inverses.push_back(invert_matrix(in_item_i));
        sent_items <= sent_items + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_mats.size() > 0 && $urandom_range(0, 99) >= pct) begin
          in_valid_i <= 1'b1;
          in_item_i <= pending_mats.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: mismatch on %s: expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Monitor: compare each result with the oldest expected inverse
  always @(posedge clk_i) begin
    int pct;
    logic [289:0] w, g;
    mi3_pkg::out_item_t want;
    pct = phase_of(sent_items) == 0 ? 79 : (phase_of(sent_items) == 1 ? 38 : 0);
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got_items <= got_items + 1;
        if (expected_inverses.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_item_o);
          errors++;
        end else begin
          want = expected_inverses.pop_front();
          w = want;
          g = out_item_o;
          for (int k = 0; k < 9; k++)
            check_field($sformatf("entry %0d", k), w[289 - 32 * k -: 32], g[289 - 32 * k -: 32]);
          check_field("singular", w[1], g[1]);
          check_field("overflow", w[0], g[0]);
        end
      end
      // one long hold-off once the pipeline is busy, so the input backs up
      if (!hold_done && sent_items == total_items / 2) begin
        hold_done <= 1'b1;
        hold_left <= HoldCycles;
        out_stall_i <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall_i <= hold_left > 1;
      end else begin
        out_stall_i <= $urandom_range(0, 99) < pct;
      end
    end
  end

  // Watchdog on cycles without any accepted item or delivered result
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni)
      idle_cycles <= 0;
    else if (idle_cycles >= WatchLimit) begin
      $display("status: fail");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    logic signed [31:0] mx, mn;
    mx = 32'sh7fff_ffff;
    mn = 32'sh8000_0000;
    // directed matrices
    pending_mats.push_back(make_matrix(One, 0, 0, 0, One, 0, 0, 0, One));
    pending_mats.push_back(make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_mats.push_back(make_matrix(mx, 0, 0, 0, mx, 0, 0, 0, mx));
    pending_mats.push_back(make_matrix(mn, 0, 0, 0, mn, 0, 0, 0, mn));
    pending_mats.push_back(make_matrix(mn, mx, mn, mx, mn, mx, mn, mx, mx));
    pending_mats.push_back(make_matrix(mx, mx, mx, mx, mx, mx, mx, mx, mx));
    pending_mats.push_back(make_matrix(1, 0, 0, 0, 1, 0, 0, 0, 1));
    pending_mats.push_back(make_matrix(-1, 0, 0, 0, 1, 0, 0, 0, 1));
    pending_mats.push_back(make_matrix(2 * One, 0, 0, 0, 2 * One, 0, 0, 0, 2 * One));
    pending_mats.push_back(make_matrix(3 * One, 0, 0, 0, 3 * One, 0, 0, 0, 3 * One));
    pending_mats.push_back(make_matrix(0, One, 0, One, 0, 0, 0, 0, One));
    pending_mats.push_back(make_matrix(One, 2 * One, 3 * One, 4 * One, 5 * One, 6 * One,
                                       7 * One, 8 * One, 9 * One));
    pending_mats.push_back(make_matrix(2 * One, -One, 0, -One, 2 * One, -One,
                                       0, -One, 2 * One));
    pending_mats.push_back(make_matrix(-32'sd1, -32'sd1, 0, 1, -32'sd1, 0, 0, 0, -32'sd1));
    pending_mats.push_back(make_matrix(One, 1, 0, 0, One, 0, 0, 0, -One));
    pending_mats.push_back(make_matrix(mx, mn, 0, mn, mx, 0, 0, 0, 1));
    for (int k = 0; k < NumRandom; k++) pending_mats.push_back(random_matrix());
    total_items = pending_mats.size();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait until every item is sent and every result checked
    while (!(sent_items == total_items && expected_inverses.size() == 0))
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
